// ===== hw/rtl/sspf_pkg.sv =====
// Shared types and constants of the sensor sample packet framer.
// Packet layout, hash constants, register indexes and the controller command word.
// No dependencies.
package sspf_pkg;

    localparam int PKT_LEN    = 38;
    localparam int HASHED_LEN = 34;
    localparam int NUM_WORDS  = 7;
    localparam int WORD_W     = 16;
    localparam int WORDS_W    = NUM_WORDS * WORD_W;
    localparam int HDR_W      = HASHED_LEN * 8;
    localparam int POS_W      = 6;
    localparam int S_TDATA_W  = 120;
    localparam int M_TDATA_W  = 8;

    localparam int PERIOD_W     = 10;
    localparam int LIMIT_W      = 8;
    localparam int COOL_W       = 8;
    localparam int STREAK_W     = 9;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 10;

    localparam logic [31:0] PKT_MAGIC   = 32'h3155_4D49;
    localparam logic [15:0] PKT_VERSION = 16'd1;
    localparam logic [15:0] PKT_SIZE    = 16'd38;
    localparam logic [31:0] FNV_OFFSET  = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME   = 32'h0100_0193;

    localparam logic [STREAK_W-1:0] STREAK_MAX = 9'd511;

    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_LIMIT    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COOLDOWN      = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd20;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 8'd10;
    localparam logic [COOL_W-1:0]   COOL_RESET   = 8'd25;

    typedef struct packed {
        logic load;
        logic advance;
        logic hash_phase;
    } sspf_cmd_t;

endpackage

// ===== hw/rtl/sspf_ctrl.sv =====
// Controller of the packet framer: sample acceptance and byte sequencing.
// Uses sspf_pkg; drives the datapath through sspf_cmd_t.
module sspf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                m_tlast,
    output sspf_pkg::sspf_cmd_t cmd
);
    import sspf_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PKT_LEN - 1);
    localparam logic [POS_W-1:0] POS_HASH = POS_W'(HASHED_LEN);

    logic             state_reg, state_next;
    logic [POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic             in_hs, out_hs, at_last;

    assign s_tready = aresetn & (state_reg == ST_IDLE);
    assign m_tvalid = aresetn & (state_reg == ST_SEND);
    assign in_hs    = s_tvalid & s_tready;
    assign out_hs   = m_tvalid & m_tready;
    assign at_last  = (byte_pos_reg == POS_LAST);
    assign m_tlast  = at_last;

    assign cmd.load       = in_hs;
    assign cmd.advance    = out_hs;
    assign cmd.hash_phase = (byte_pos_reg >= POS_HASH);

    always_comb begin
        state_next    = state_reg;
        byte_pos_next = byte_pos_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_hs) begin
                    state_next    = ST_SEND;
                    byte_pos_next = '0;
                end
            end
            ST_SEND: begin
                if (out_hs) begin
                    if (at_last) begin
                        state_next    = ST_IDLE;
                        byte_pos_next = '0;
                    end else begin
                        byte_pos_next = byte_pos_reg + POS_W'(1);
                    end
                end
            end
            default: begin
                state_next    = ST_IDLE;
                byte_pos_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            byte_pos_reg <= '0;
        end else begin
            state_reg    <= state_next;
            byte_pos_reg <= byte_pos_next;
        end
    end

endmodule

// ===== hw/rtl/sspf_datapath.sv =====
// Datapath of the packet framer: configuration, counters, streak logic,
// packet shift line and serial FNV-1a hash. Uses sspf_pkg.
module sspf_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sspf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [sspf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [sspf_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    input  sspf_pkg::sspf_cmd_t                cmd,
    output logic [sspf_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser
);
    import sspf_pkg::*;

    logic [PERIOD_W-1:0] period_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [COOL_W-1:0]   cool_cfg_reg;

    logic [31:0]         seq_reg;
    logic [31:0]         time_reg, time_next;
    logic [15:0]         rderr_reg, rderr_next;
    logic [15:0]         snderr_reg, snderr_next;
    logic [STREAK_W-1:0] streak_reg, streak_next, streak_grow;
    logic [COOL_W-1:0]   cooldown_reg, cooldown_next;
    logic                request_reg, request_next;

    logic [HDR_W-1:0]    shift_reg;
    logic [31:0]         hash_reg, hash_mix;

    logic [WORDS_W-1:0]  words, words_kept;
    logic                read_ok, prev_tx_failed, all_zero;

    assign words          = s_tdata[WORDS_W-1:0];
    assign prev_tx_failed = s_tdata[WORDS_W];
    assign read_ok        = s_tuser;
    assign all_zero       = (words == '0);
    assign words_kept     = read_ok ? words : '0;

    assign snderr_next = snderr_reg + 16'(prev_tx_failed);
    assign time_next   = time_reg + 32'(period_reg);
    assign rderr_next  = rderr_reg + 16'(!read_ok);

    always_comb begin
        if (read_ok && all_zero) begin
            streak_grow = (streak_reg == STREAK_MAX) ? streak_reg
                                                     : streak_reg + STREAK_W'(1);
        end else begin
            streak_grow = '0;
        end
        streak_next   = streak_grow;
        cooldown_next = cooldown_reg;
        request_next  = 1'b0;
        if (cooldown_reg != '0) begin
            cooldown_next = cooldown_reg - COOL_W'(1);
        end else if (streak_grow >= STREAK_W'(limit_reg)) begin
            request_next  = 1'b1;
            streak_next   = '0;
            cooldown_next = cool_cfg_reg;
        end
    end

    assign hash_mix = 32'((hash_reg ^ {24'd0, shift_reg[7:0]}) * FNV_PRIME);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= PERIOD_RESET;
            limit_reg    <= LIMIT_RESET;
            cool_cfg_reg <= COOL_RESET;
            seq_reg      <= '0;
            time_reg     <= '0;
            rderr_reg    <= '0;
            snderr_reg   <= '0;
            streak_reg   <= '0;
            cooldown_reg <= '0;
            request_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_SAMPLE_PERIOD: period_reg   <= cfg_wdata;
                    REG_ZERO_LIMIT:    limit_reg    <= cfg_wdata[LIMIT_W-1:0];
                    REG_COOLDOWN:      cool_cfg_reg <= cfg_wdata[COOL_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                seq_reg      <= seq_reg + 32'd1;
                time_reg     <= time_next;
                rderr_reg    <= rderr_next;
                snderr_reg   <= snderr_next;
                streak_reg   <= streak_next;
                cooldown_reg <= cooldown_next;
                request_reg  <= request_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            shift_reg <= {snderr_next, rderr_next, words_kept, time_next, seq_reg,
                          PKT_SIZE, PKT_VERSION, PKT_MAGIC};
            hash_reg  <= FNV_OFFSET;
        end else if (cmd.advance) begin
            if (cmd.hash_phase) begin
                hash_reg <= hash_reg >> 8;
            end else begin
                hash_reg  <= hash_mix;
                shift_reg <= shift_reg >> 8;
            end
        end
    end

    assign m_tdata = cmd.hash_phase ? hash_reg[7:0] : shift_reg[7:0];
    assign m_tuser = request_reg;

endmodule

// ===== hw/rtl/sensor_sample_packet_framer.sv =====
// Sensor sample packet framer, top level.
// Instantiates sspf_ctrl and sspf_datapath; uses sspf_pkg.
//
// Usage:
//   Slave channel (s_*): one sensor sample per word. s_tdata carries the seven
//   signed 16-bit readings and the previous-transmit-failed flag; s_tuser
//   carries the read-ok flag.
//   Master channel (m_*): the 38-byte little-endian packet, one byte per word,
//   m_tlast on the final byte, m_tuser set on every byte of a packet that
//   requests a sensor reinit.
//   Config port: write cfg_wdata to register cfg_addr while cfg_wr_en is high
//   (0 sample period, 1 zero-frame limit, 2 cooldown frames); write only while
//   idle.
// Timing:
//   Byte 0 appears on the cycle after a sample is accepted, and the packet
//   leaves at one byte per cycle while m_tready is high. The serial hash unit,
//   which folds in one byte per sent byte, sets this rate.
//   s_tready is low while a packet is being sent.
// Reset: counters, streak and cooldown clear, registers return to 20/10/25.
// Stall: with m_tready low the current byte and all state hold.
module sensor_sample_packet_framer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sspf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [sspf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // accel_x, accel_y, accel_z, temp_reading, gyro_x, gyro_y, gyro_z,
    // prev_tx_failed, zero fill
    input  logic [sspf_pkg::S_TDATA_W-1:0]     s_tdata,
    // read_ok
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // packet_byte
    output logic [sspf_pkg::M_TDATA_W-1:0]     m_tdata,
    // last_byte
    output logic                               m_tlast,
    // reinit_request
    output logic                               m_tuser
);
    import sspf_pkg::*;

    sspf_cmd_t cmd;

    sspf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cmd      (cmd)
    );

    sspf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
